// File: rtl/core/sine_tone_with_fade_top_macros.svh
// Assertion helpers, clocked on i_clk, off during reset.
`ifndef SINE_TONE_WITH_FADE_TOP_MACROS_SVH
`define SINE_TONE_WITH_FADE_TOP_MACROS_SVH

`define SNTF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SNTF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sntf_pkg.sv
package sntf_pkg;

    localparam int unsigned SINE_TABLE_BITS_DEF = 10;
    localparam int unsigned COUNT_BITS_DEF      = 16;

    localparam int unsigned FADE_W  = 12;
    localparam int unsigned VOL_W   = 16;
    localparam int unsigned SIN_W   = 17;
    localparam int unsigned NUM_W   = FADE_W;
    localparam int unsigned AMP_W   = 14;
    localparam int unsigned PROD_W  = VOL_W + SIN_W + NUM_W + AMP_W;
    localparam int unsigned QUO_W   = PROD_W - 32;
    localparam int unsigned MAG_W   = 14;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned LENX_W  = 24;

    localparam logic [AMP_W-1:0] AMP_SCALE = AMP_W'(12000);
    localparam logic [FADE_W-1:0] FADE_RESET = FADE_W'(120);
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic              opcode;
        logic [31:0]       phase_step;
        logic [LEN_W-1:0]  tone_length;
        logic [VOL_W-1:0]  volume;
    } t_in_word;

    typedef struct packed {
        logic signed [14:0] sample;
        logic               last_sample;
    } t_out_word;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // quarter-wave entry k: Taylor series in Q30, rounded to Q16
    function automatic logic [SIN_W-1:0] sin_entry(input int unsigned k,
                                                   input int unsigned tab_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] s;
        logic [63:0] r;
        x    = (HALF_PI_Q30 * 64'(k)) >> tab_bits;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        neg  = 64'd0;
        for (int n = 1; n <= 7; n++) begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        s = (pos > neg) ? pos - neg : 64'd0;
        r = (s + 64'd8192) >> 14;
        if (r > 64'd65536) begin
            r = 64'd65536;
        end
        return r[SIN_W-1:0];
    endfunction

endpackage

// File: rtl/core/sntf_sine_rom.sv
module sntf_sine_rom #(
    parameter int unsigned TAB_BITS = sntf_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic [TAB_BITS:0]         i_addr,
    output logic [sntf_pkg::SIN_W-1:0] o_data
);
    import sntf_pkg::*;

    localparam int unsigned TAB_LEN = (1 << TAB_BITS) + 1;

    logic [SIN_W-1:0] tab [TAB_LEN];
    logic [SIN_W-1:0] r_data;

    for (genvar k = 0; k < TAB_LEN; k++) begin : g_tab
        localparam logic [SIN_W-1:0] ENTRY = sin_entry(k, TAB_BITS);
        assign tab[k] = ENTRY;
    end

    always_ff @(posedge i_clk) begin
        r_data <= tab[i_addr];
    end

    assign o_data = r_data;

endmodule

// File: rtl/core/sntf_serial_arith.sv
module sntf_serial_arith (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sntf_pkg::VOL_W-1:0]  i_vol,
    input  logic [sntf_pkg::SIN_W-1:0]  i_sin,
    input  logic [sntf_pkg::NUM_W-1:0]  i_num,
    input  logic [sntf_pkg::FADE_W-1:0] i_den,
    output logic                        o_done,
    output logic [sntf_pkg::MAG_W-1:0]  o_mag
);
    import sntf_pkg::*;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_MS   = 3'd1;
    localparam logic [2:0] PH_MN   = 3'd2;
    localparam logic [2:0] PH_MK   = 3'd3;
    localparam logic [2:0] PH_DIV  = 3'd4;

    logic [2:0]        r_ph;
    logic [4:0]        r_cnt;
    logic [PROD_W-1:0] r_m;
    logic [PROD_W-1:0] r_p;
    logic [SIN_W-1:0]  r_q;
    logic [NUM_W-1:0]  r_num;
    logic [FADE_W-1:0] r_den;
    logic [QUO_W-1:0]  r_d;
    logic [FADE_W-1:0] r_rem;
    logic              r_done;

    logic [PROD_W-1:0] p_next;
    logic [FADE_W:0]   rem_sh;
    logic              ge;

    assign p_next = r_q[0] ? r_p + r_m : r_p;
    assign rem_sh = {r_rem, r_d[QUO_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_ph == PH_DIV) && (r_cnt == 5'd0);
            unique case (r_ph)
                PH_IDLE: begin
                    if (i_start) begin
                        r_ph <= PH_MS;
                    end
                end
                PH_MS: begin
                    if (r_cnt == 5'd0) begin
                        r_ph <= PH_MN;
                    end
                end
                PH_MN: begin
                    if (r_cnt == 5'd0) begin
                        r_ph <= PH_MK;
                    end
                end
                PH_MK: begin
                    if (r_cnt == 5'd0) begin
                        r_ph <= PH_DIV;
                    end
                end
                PH_DIV: begin
                    if (r_cnt == 5'd0) begin
                        r_ph <= PH_IDLE;
                    end
                end
                default: r_ph <= PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_ph)
            PH_IDLE: begin
                r_m   <= PROD_W'(i_vol);
                r_p   <= '0;
                r_q   <= i_sin;
                r_num <= i_num;
                r_den <= i_den;
                r_cnt <= 5'(SIN_W - 1);
            end
            PH_MS, PH_MN, PH_MK: begin
                if (r_cnt == 5'd0) begin
                    r_m <= p_next;
                    r_p <= '0;
                    if (r_ph == PH_MS) begin
                        r_q   <= SIN_W'(r_num);
                        r_cnt <= 5'(NUM_W - 1);
                    end else if (r_ph == PH_MN) begin
                        r_q   <= SIN_W'(AMP_SCALE);
                        r_cnt <= 5'(AMP_W - 1);
                    end else begin
                        r_d   <= p_next[PROD_W-1:32];
                        r_rem <= '0;
                        r_cnt <= 5'(QUO_W - 1);
                    end
                end else begin
                    r_p   <= p_next;
                    r_m   <= r_m << 1;
                    r_q   <= r_q >> 1;
                    r_cnt <= r_cnt - 5'd1;
                end
            end
            PH_DIV: begin
                r_rem <= ge ? FADE_W'(rem_sh - {1'b0, r_den}) : rem_sh[FADE_W-1:0];
                r_d   <= {r_d[QUO_W-2:0], ge};
                r_cnt <= r_cnt - 5'd1;
            end
            default: r_cnt <= '0;
        endcase
    end

    assign o_done = r_done;
    assign o_mag  = r_d[MAG_W-1:0];

endmodule

// File: rtl/core/sine_tone_with_fade_top.sv
// channel | direction | handshake                   | word
// in      | input     | i_in_valid / o_in_ready     | t_in_word  (opcode, step, length, volume)
// out     | output    | o_out_valid / i_out_ready   | t_out_word (sample, last_sample)
// cfg     | input     | APB psel/penable, pready=1  | fade_samples at byte address 0
// A start word gives no result.
// An active tick runs through a table read, then the shared bit-serial unit
// (17 + 12 + 14 multiply steps, 27 divide steps), then output load.
// A tick while idle gives a zero word through the put state.
// A stalled output word holds; the next input is taken while it waits.
// Reset is synchronous, active low; fade_samples returns to 120.
module sine_tone_with_fade_top #(
    parameter int unsigned SINE_TABLE_BITS = sntf_pkg::SINE_TABLE_BITS_DEF,
    parameter int unsigned COUNT_BITS      = sntf_pkg::COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sntf_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sntf_pkg::t_out_word o_out_word,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [2:0]          i_paddr,
    input  logic [31:0]         i_pwdata,
    output logic [31:0]         o_prdata,
    output logic                o_pready
);
    import sntf_pkg::*;

    `include "sine_tone_with_fade_top_macros.svh"

    localparam int unsigned CW = COUNT_BITS;
    localparam int unsigned TB = SINE_TABLE_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ROM  = 2'd1;
    localparam logic [1:0] ST_CALC = 2'd2;
    localparam logic [1:0] ST_PUT  = 2'd3;

    logic [1:0]        r_state;
    logic [FADE_W-1:0] r_fade;
    logic [31:0]       r_phase;
    logic [31:0]       r_step;
    logic [CW-1:0]     r_sidx;
    logic [CW-1:0]     r_len;
    logic [VOL_W-1:0]  r_vol;
    logic              r_active;
    logic [NUM_W-1:0]  r_num;
    logic [FADE_W-1:0] r_den;
    logic              r_res_neg;
    logic              r_res_last;
    logic [MAG_W-1:0]  r_res_mag;
    logic              r_out_valid;
    t_out_word         r_out_word;

    logic              acc_in;
    logic              cfg_wr;
    logic [LENX_W-1:0] len_x;
    logic [LENX_W-1:0] cnt_max;
    logic [CW-1:0]     len_sat;
    logic [CW:0]       i_x;
    logic [CW:0]       n_x;
    logic [CW:0]       den_x;
    logic [NUM_W-1:0]  num_c;
    logic [FADE_W-1:0] den_c;
    logic              last_c;
    logic [TB-1:0]     tab_idx;
    logic [TB:0]       rom_addr;
    logic [SIN_W-1:0]  rom_data;
    logic              ar_done;
    logic [MAG_W-1:0]  ar_mag;
    logic              out_free;
    logic [14:0]       mag_x;

    assign o_in_ready = (r_state == ST_IDLE);
    assign acc_in     = i_in_valid && o_in_ready;
    assign cfg_wr     = i_psel && i_penable && i_pwrite && (i_paddr[2] == 1'b0);
    assign o_pready   = 1'b1;
    assign o_prdata   = (i_paddr[2] == 1'b0) ? 32'(r_fade) : 32'd0;

    assign len_x   = LENX_W'(i_in_word.tone_length);
    assign cnt_max = LENX_W'((64'd1 << CW) - 64'd1);
    assign len_sat = (len_x > cnt_max) ? cnt_max[CW-1:0] : len_x[CW-1:0];

    assign i_x   = {1'b0, r_sidx};
    assign n_x   = {1'b0, r_len};
    assign den_x = (CW + 1)'(r_fade);

    always_comb begin
        if (r_fade == '0) begin
            num_c = NUM_W'(1);
            den_c = FADE_W'(1);
        end else begin
            den_c = r_fade;
            priority if (i_x < den_x) begin
                num_c = r_sidx[NUM_W-1:0];
            end else if (i_x + den_x > n_x) begin
                num_c = NUM_W'(n_x - i_x);
            end else begin
                num_c = r_fade;
            end
        end
    end

    assign last_c   = (i_x + (CW + 1)'(1)) == n_x;
    assign tab_idx  = r_phase[29 -: TB];
    assign rom_addr = r_phase[30] ? ((TB + 1)'(1) << TB) - {1'b0, tab_idx} : {1'b0, tab_idx};

    sntf_sine_rom #(
        .TAB_BITS(TB)
    ) u_rom (
        .i_clk (i_clk),
        .i_addr(rom_addr),
        .o_data(rom_data)
    );

    sntf_serial_arith u_arith (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_state == ST_ROM),
        .i_vol  (r_vol),
        .i_sin  (rom_data),
        .i_num  (r_num),
        .i_den  (r_den),
        .o_done (ar_done),
        .o_mag  (ar_mag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade <= FADE_RESET;
        end else if (cfg_wr) begin
            r_fade <= i_pwdata[FADE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_active <= 1'b0;
            r_phase  <= '0;
            r_step   <= '0;
            r_sidx   <= '0;
            r_len    <= '0;
            r_vol    <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (acc_in) begin
                        if (i_in_word.opcode == OP_START) begin
                            r_step   <= i_in_word.phase_step;
                            r_len    <= len_sat;
                            r_vol    <= i_in_word.volume;
                            r_phase  <= '0;
                            r_sidx   <= '0;
                            r_active <= (len_sat != '0);
                        end else if (!r_active || (r_sidx >= r_len)) begin
                            r_active   <= 1'b0;
                            r_res_mag  <= '0;
                            r_res_neg  <= 1'b0;
                            r_res_last <= 1'b0;
                            r_state    <= ST_PUT;
                        end else begin
                            r_num      <= num_c;
                            r_den      <= den_c;
                            r_res_neg  <= r_phase[31];
                            r_res_last <= last_c;
                            r_phase    <= r_phase + r_step;
                            r_sidx     <= r_sidx + CW'(1);
                            if (last_c) begin
                                r_active <= 1'b0;
                            end
                            r_state <= ST_ROM;
                        end
                    end
                end
                ST_ROM: begin
                    r_state <= ST_CALC;
                end
                ST_CALC: begin
                    if (ar_done) begin
                        r_res_mag <= ar_mag;
                        r_state   <= ST_PUT;
                    end
                end
                ST_PUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign mag_x    = {1'b0, r_res_mag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_PUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_PUT && out_free) begin
            r_out_word.sample      <= r_res_neg ? -mag_x : mag_x;
            r_out_word.last_sample <= r_res_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `SNTF_ASSERT_IMP(a_done_in_calc, ar_done, r_state == ST_CALC, "arith done outside calc")
    `SNTF_ASSERT_IMP(a_idx_in_range, r_active, r_sidx < r_len, "active tone past its length")
    `SNTF_ASSERT_IMP(a_sample_range, o_out_valid,
        (o_out_word.sample <= 15'sd12000) && (o_out_word.sample >= -15'sd12000),
        "sample out of range")
    `SNTF_ASSERT_NXT(a_rom_to_calc, r_state == ST_ROM, r_state == ST_CALC, "rom state stuck")

endmodule
